>>> rtl/cpd_pkg.sv
// Shared types, constants and microcode table for the cascaded PD heading controller.
`default_nettype none
package cpd_pkg;

  localparam int MODE_W    = 2;
  localparam int PE_W      = 24;
  localparam int GR_W      = 24;
  localparam int DRIVE_W   = 22;
  localparam int FLAGS_W   = 4;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int GLIM_W    = 23;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 23;
  localparam int STEP_W    = 4;

  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POS_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_KD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_KP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_KD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT = 3'd4;

  localparam logic [GAIN_W-1:0] POS_KP_RST     = 16'd4634;
  localparam logic [GAIN_W-1:0] POS_KD_RST     = 16'd169;
  localparam logic [GAIN_W-1:0] RATE_KP_RST    = 16'd640;
  localparam logic [GAIN_W-1:0] RATE_KD_RST    = 16'd38;
  localparam logic [GLIM_W-1:0] GYRO_LIMIT_RST = 23'd409600;

  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DPOS  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MKD   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ACC1  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TGT   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_OVR   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RERR  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DRATE = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MRKD  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ACC2  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_OUT   = 4'd10;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_KP_PE,
    MS_KD_DPOS,
    MS_RKP_RERR,
    MS_RKD_DRATE
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_WAIT_IN,
    J_SKIP_STRAIGHT,
    J_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic              ld_in;
    logic              do_dpos;
    logic              do_tgt;
    logic              do_ovr;
    logic              do_rerr;
    logic              do_drate;
    logic              do_out;
    mul_sel_t          mul;
    acc_op_t           acc;
    jmp_t              jc;
    logic [STEP_W-1:0] tgt;
  } cw_t;

  typedef struct packed {
    logic     ld_in;
    logic     do_dpos;
    logic     do_tgt;
    logic     do_ovr;
    logic     do_rerr;
    logic     do_drate;
    logic     do_out;
    mul_sel_t mul;
    acc_op_t  acc;
  } dp_ctl_t;

  typedef struct packed {
    logic turn;
    logic out_free;
  } dp_sts_t;

  localparam cw_t CW_NOP = '{
    ld_in: 1'b0, do_dpos: 1'b0, do_tgt: 1'b0, do_ovr: 1'b0, do_rerr: 1'b0,
    do_drate: 1'b0, do_out: 1'b0, mul: MS_NONE, acc: ACC_HOLD, jc: J_NEXT,
    tgt: STEP_IDLE
  };

  // microcode ROM
  function automatic cw_t rom_word(input logic [STEP_W-1:0] a);
    cw_t w;
    w = CW_NOP;
    unique case (a)
      STEP_IDLE: begin
        w.ld_in = 1'b1;
        w.jc    = J_WAIT_IN;
      end
      STEP_DPOS: begin
        w.do_dpos = 1'b1;
        w.mul     = MS_KP_PE;
      end
      STEP_MKD: begin
        w.mul = MS_KD_DPOS;
        w.acc = ACC_LOAD;
      end
      STEP_ACC1: begin
        w.acc = ACC_ADD;
      end
      STEP_TGT: begin
        w.do_tgt = 1'b1;
        w.jc     = J_SKIP_STRAIGHT;
        w.tgt    = STEP_RERR;
      end
      STEP_OVR: begin
        w.do_ovr = 1'b1;
      end
      STEP_RERR: begin
        w.do_rerr = 1'b1;
      end
      STEP_DRATE: begin
        w.do_drate = 1'b1;
        w.mul      = MS_RKP_RERR;
      end
      STEP_MRKD: begin
        w.mul = MS_RKD_DRATE;
        w.acc = ACC_LOAD;
      end
      STEP_ACC2: begin
        w.acc = ACC_ADD;
      end
      STEP_OUT: begin
        w.do_out = 1'b1;
        w.jc     = J_WAIT_OUT;
        w.tgt    = STEP_IDLE;
      end
      default: begin
        w.jc  = J_WAIT_OUT;
        w.tgt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cpd_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`default_nettype none
module cpd_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire cpd_pkg::dp_sts_t sts,
  output cpd_pkg::dp_ctl_t     ctl
);
  import cpd_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  cw_t               cw;
  logic              in_fire;
  logic              out_wr;

  assign cw       = rom_word(step_r);
  assign in_stall = (cw.jc != J_WAIT_IN);
  assign in_fire  = in_valid && !in_stall;
  assign out_wr   = cw.do_out && sts.out_free;

  always_comb begin
    ctl.ld_in    = cw.ld_in && in_fire;
    ctl.do_dpos  = cw.do_dpos;
    ctl.do_tgt   = cw.do_tgt;
    ctl.do_ovr   = cw.do_ovr;
    ctl.do_rerr  = cw.do_rerr;
    ctl.do_drate = cw.do_drate;
    ctl.do_out   = out_wr;
    ctl.mul      = cw.mul;
    ctl.acc      = cw.acc;
  end

  always_comb begin
    step_nxt = step_r + STEP_W'(1);
    unique case (cw.jc)
      J_NEXT: step_nxt = step_r + STEP_W'(1);
      J_WAIT_IN: begin
        if (!in_fire) step_nxt = step_r;
      end
      J_SKIP_STRAIGHT: begin
        if (!sts.turn) step_nxt = cw.tgt;
      end
      J_WAIT_OUT: step_nxt = sts.out_free ? cw.tgt : step_r;
      default: step_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (step_r == STEP_DPOS))
    else $error("accepted request did not start the program");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_OUT)
    else $error("step counter left the program");

  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.do_out) |=> (step_r == STEP_IDLE))
    else $error("result write did not return to idle");

endmodule
`default_nettype wire

>>> rtl/cpd_dp.sv
// Datapath: gain registers, shared multiplier, accumulator, clamps and loop history.
`default_nettype none
module cpd_dp #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cpd_pkg::dp_ctl_t                  ctl,
  output cpd_pkg::dp_sts_t                       sts,
  input  wire logic                              cfg_wr,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpd_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire logic [cpd_pkg::MODE_W-1:0]        in_mode,
  input  wire logic signed [cpd_pkg::PE_W-1:0]   in_position_error,
  input  wire logic signed [cpd_pkg::GR_W-1:0]   in_gyro_rate,
  input  wire logic                              in_clear_history,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [cpd_pkg::DRIVE_W-1:0]     out_drive_offset,
  output logic [cpd_pkg::FLAGS_W-1:0]            out_sat_flags
);
  import cpd_pkg::*;

  localparam int POS_LIM_I  = ((403 << FRAC_BITS) + 5) / 10;
  localparam int RATE_LIM_I = 700 << FRAC_BITS;
  localparam int OUT_LIM_I  = 6500 << FRAC_BITS;
  localparam int TURN_I     = 1600 << FRAC_BITS;
  localparam int TW  = ($clog2(TURN_I) + 2 > PE_W) ? $clog2(TURN_I) + 2 : PE_W;
  localparam int DW  = PE_W + 1;
  localparam int RW  = TW + 1;
  localparam int PRW = RW + GAIN_W + 1;
  localparam int AW  = PRW + 1;
  localparam int SW  = AW - GAIN_FRAC;

  localparam logic signed [DW-1:0] POS_LIM  = DW'(POS_LIM_I);
  localparam logic signed [RW:0]   RATE_LIM = (RW + 1)'(RATE_LIM_I);
  localparam logic signed [SW-1:0] OUT_LIM  = SW'(OUT_LIM_I);
  localparam logic signed [TW-1:0] TURN     = TW'(TURN_I);

  logic [GAIN_W-1:0] pos_kp_r, pos_kd_r, rate_kp_r, rate_kd_r;
  logic [GLIM_W-1:0] gyro_limit_r;

  logic signed [PE_W-1:0] pe_r, prev_pos_r;
  logic signed [GR_W-1:0] gr_r;
  logic                   turn_r, right_r;
  logic signed [DW-1:0]   dpos_r;
  logic signed [TW-1:0]   target_r;
  logic signed [RW-1:0]   rerr_r, prev_rate_r, drate_r;
  logic signed [PRW-1:0]  prod_r;
  logic signed [AW-1:0]   acc_r;
  logic [FLAGS_W-1:0]     sat_r;
  logic                   out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic [FLAGS_W-1:0]     flags_out_r;

  logic [GAIN_W-1:0]      gain;
  logic signed [RW-1:0]   opnd;
  logic signed [DW-1:0]   pdiff, dpos_c;
  logic                   pdiff_sat;
  logic signed [SW-1:0]   acc_sh, glim, tgt_c, y_c;
  logic                   tgt_sat, y_sat;
  logic signed [RW:0]     rdiff, drate_c;
  logic                   rdiff_sat;

  assign sts.turn     = turn_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_kp_r     <= POS_KP_RST;
      pos_kd_r     <= POS_KD_RST;
      rate_kp_r    <= RATE_KP_RST;
      rate_kd_r    <= RATE_KD_RST;
      gyro_limit_r <= GYRO_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_POS_KP:     pos_kp_r     <= cfg_data[GAIN_W-1:0];
        REG_POS_KD:     pos_kd_r     <= cfg_data[GAIN_W-1:0];
        REG_RATE_KP:    rate_kp_r    <= cfg_data[GAIN_W-1:0];
        REG_RATE_KD:    rate_kd_r    <= cfg_data[GAIN_W-1:0];
        REG_GYRO_LIMIT: gyro_limit_r <= cfg_data[GLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gain = '0;
    opnd = '0;
    unique case (ctl.mul)
      MS_KP_PE: begin
        gain = pos_kp_r;
        opnd = RW'(pe_r);
      end
      MS_KD_DPOS: begin
        gain = pos_kd_r;
        opnd = RW'(dpos_r);
      end
      MS_RKP_RERR: begin
        gain = rate_kp_r;
        opnd = rerr_r;
      end
      MS_RKD_DRATE: begin
        gain = rate_kd_r;
        opnd = drate_r;
      end
      default: ;
    endcase
  end

  // clamps
  always_comb begin
    pdiff     = DW'(pe_r) - DW'(prev_pos_r);
    pdiff_sat = (pdiff > POS_LIM) || (pdiff < -POS_LIM);
    if (pdiff > POS_LIM)       dpos_c = POS_LIM;
    else if (pdiff < -POS_LIM) dpos_c = -POS_LIM;
    else                       dpos_c = pdiff;

    acc_sh  = acc_r[AW-1:GAIN_FRAC];
    glim    = $signed({{(SW-GLIM_W){1'b0}}, gyro_limit_r});
    tgt_sat = (acc_sh > glim) || (acc_sh < -glim);
    if (acc_sh > glim)       tgt_c = glim;
    else if (acc_sh < -glim) tgt_c = -glim;
    else                     tgt_c = acc_sh;

    y_sat = (acc_sh > OUT_LIM) || (acc_sh < -OUT_LIM);
    if (acc_sh > OUT_LIM)       y_c = OUT_LIM;
    else if (acc_sh < -OUT_LIM) y_c = -OUT_LIM;
    else                        y_c = acc_sh;

    rdiff     = (RW + 1)'(rerr_r) - (RW + 1)'(prev_rate_r);
    rdiff_sat = (rdiff > RATE_LIM) || (rdiff < -RATE_LIM);
    if (rdiff > RATE_LIM)       drate_c = RATE_LIM;
    else if (rdiff < -RATE_LIM) drate_c = -RATE_LIM;
    else                        drate_c = rdiff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pos_r  <= '0;
      prev_rate_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.ld_in && in_clear_history) begin
        prev_pos_r  <= '0;
        prev_rate_r <= '0;
      end
      if (ctl.do_dpos) prev_pos_r <= pe_r;
      if (ctl.do_drate) prev_rate_r <= rerr_r;
      if (ctl.do_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      pe_r    <= in_position_error;
      gr_r    <= in_gyro_rate;
      turn_r  <= (in_mode == MODE_RIGHT) || (in_mode == MODE_LEFT);
      right_r <= (in_mode == MODE_RIGHT);
      sat_r   <= '0;
    end
    if (ctl.do_dpos) begin
      dpos_r   <= dpos_c;
      sat_r[0] <= pdiff_sat;
    end
    if (ctl.do_tgt) begin
      target_r <= $signed(tgt_c[TW-1:0]);
      sat_r[1] <= tgt_sat;
    end
    if (ctl.do_ovr) target_r <= right_r ? TURN : -TURN;
    if (ctl.do_rerr) rerr_r <= -RW'(target_r) - RW'(gr_r);
    if (ctl.do_drate) begin
      drate_r  <= $signed(drate_c[RW-1:0]);
      sat_r[2] <= rdiff_sat;
    end
    prod_r <= $signed({1'b0, gain}) * opnd;
    unique case (ctl.acc)
      ACC_LOAD: acc_r <= AW'(prod_r);
      ACC_ADD:  acc_r <= acc_r + AW'(prod_r);
      default:  acc_r <= acc_r;
    endcase
    if (ctl.do_out) begin
      drive_r     <= $signed(y_c[DRIVE_W-1:0]);
      flags_out_r <= {y_sat, sat_r[2:0]};
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_offset = drive_r;
  assign out_sat_flags    = flags_out_r;

  a_dpos_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(ctl.do_dpos) && sat_r[0]) |-> ((dpos_r == POS_LIM) || (dpos_r == -POS_LIM)))
    else $error("position difference flagged but not at its limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ctl.do_out)
    else $error("result register overwritten while held");

endmodule
`default_nettype wire

>>> rtl/cascaded_pd_heading_controller_top.sv
// Top level of the cascaded PD heading controller.
`default_nettype none
// One request in, one result out. A request is taken when the sequencer sits in its
// idle step; the control program then runs its steps on one shared 17 x (target+1)-bit
// multiplier, skipping the turn-override step in straight mode; the next request is taken
// only back in idle, after the output step, which waits while out_stall holds the previous
// result. The result register lets a new request start while the last result waits.
// Configuration writes are taken every cycle (cfg_ready is always high);
// write only while no request is in flight. Indexes beyond the register list are ignored.
module cascaded_pd_heading_controller_top #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpd_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [cpd_pkg::MODE_W-1:0]        in_mode,
  input  wire logic signed [cpd_pkg::PE_W-1:0]   in_position_error,
  input  wire logic signed [cpd_pkg::GR_W-1:0]   in_gyro_rate,
  input  wire logic                              in_clear_history,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [cpd_pkg::DRIVE_W-1:0]     out_drive_offset,
  output logic [cpd_pkg::FLAGS_W-1:0]            out_sat_flags
);
  import cpd_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  cpd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  cpd_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_mode           (in_mode),
    .in_position_error (in_position_error),
    .in_gyro_rate      (in_gyro_rate),
    .in_clear_history  (in_clear_history),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_offset  (out_drive_offset),
    .out_sat_flags     (out_sat_flags)
  );

endmodule
`default_nettype wire

>>> bench/cpd_heading_check.sv
// Checker for the heading controller: tracks config writes, predicts each result, compares.
`timescale 1ns / 100ps
module cpd_heading_check #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cpd_pkg::CFG_DAT_W-1:0]         cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [cpd_pkg::MODE_W-1:0]            in_mode,
  input  logic signed [cpd_pkg::PE_W-1:0]       in_position_error,
  input  logic signed [cpd_pkg::GR_W-1:0]       in_gyro_rate,
  input  logic                                  in_clear_history,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [cpd_pkg::DRIVE_W-1:0]    out_drive_offset,
  input  logic [cpd_pkg::FLAGS_W-1:0]           out_sat_flags,
  output int                                    mismatch_cnt,
  output int                                    outstanding
);
  import cpd_pkg::*;

  localparam longint POS_DIFF_MAX  = ((longint'(403) << FRAC_BITS) + 5) / 10;
  localparam longint RATE_DIFF_MAX = longint'(700) << FRAC_BITS;
  localparam longint DRIVE_MAX     = longint'(6500) << FRAC_BITS;
  localparam longint TURN_TARGET   = longint'(1600) << FRAC_BITS;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [FLAGS_W-1:0]        flags;
  } drive_t;

  logic [GAIN_W-1:0] outer_kp, outer_kd, inner_kp, inner_kd;
  logic [GLIM_W-1:0] target_lim;
  longint            last_pos, last_rate_err;
  drive_t            expected_drive[$];
  int                errs = 0;

  function automatic longint clip(input longint v, input longint lim, output logic hit);
    hit = 1'b1;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    hit = 1'b0;
    return v;
  endfunction

  function automatic drive_t heading_step(input logic [MODE_W-1:0] mode,
                                          input logic signed [PE_W-1:0] pe,
                                          input logic signed [GR_W-1:0] gr,
                                          input logic clr);
    longint d_pos, tgt, r_err, d_rate, y;
    logic [FLAGS_W-1:0] fl;
    drive_t res;
    if (clr) begin
      last_pos      = 0;
      last_rate_err = 0;
    end
    d_pos    = clip(longint'(pe) - last_pos, POS_DIFF_MAX, fl[0]);
    last_pos = longint'(pe);
    tgt      = (longint'(outer_kp) * longint'(pe) + longint'(outer_kd) * d_pos) >>> GAIN_FRAC;
    tgt      = clip(tgt, longint'(target_lim), fl[1]);
    if (mode == MODE_RIGHT) begin
      tgt = TURN_TARGET;
    end else if (mode == MODE_LEFT) begin
      tgt = -TURN_TARGET;
    end
    r_err         = -tgt - longint'(gr);
    d_rate        = clip(r_err - last_rate_err, RATE_DIFF_MAX, fl[2]);
    last_rate_err = r_err;
    y = (longint'(inner_kp) * r_err + longint'(inner_kd) * d_rate) >>> GAIN_FRAC;
    y = clip(y, DRIVE_MAX, fl[3]);
    res.drive = y[DRIVE_W-1:0];
    res.flags = fl;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    drive_t want;
    if (!rst_n) begin
      outer_kp      = POS_KP_RST;
      outer_kd      = POS_KD_RST;
      inner_kp      = RATE_KP_RST;
      inner_kd      = RATE_KD_RST;
      target_lim    = GYRO_LIMIT_RST;
      last_pos      = 0;
      last_rate_err = 0;
      expected_drive.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POS_KP:     outer_kp   = cfg_data[GAIN_W-1:0];
          REG_POS_KD:     outer_kd   = cfg_data[GAIN_W-1:0];
          REG_RATE_KP:    inner_kp   = cfg_data[GAIN_W-1:0];
          REG_RATE_KD:    inner_kd   = cfg_data[GAIN_W-1:0];
          REG_GYRO_LIMIT: target_lim = cfg_data[GLIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          errs++;
          $error("result with no request pending: drive_offset %0d sat_flags %0h",
                 out_drive_offset, out_sat_flags);
        end else begin
          want = expected_drive.pop_front();
          if (out_drive_offset !== want.drive) begin
            errs++;
            $error("drive_offset: expected %0d, actual %0d", want.drive, out_drive_offset);
          end
          if (out_sat_flags !== want.flags) begin
            errs++;
            $error("sat_flags: expected %0h, actual %0h", want.flags, out_sat_flags);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_drive.push_back(heading_step(in_mode, in_position_error, in_gyro_rate,
                                              in_clear_history));
      end
    end
    outstanding  <= expected_drive.size();
    mismatch_cnt <= errs;
  end

endmodule

>>> bench/cascaded_pd_heading_controller_top_test.sv
// Testbench top for the heading controller: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module cascaded_pd_heading_controller_top_test;
  import cpd_pkg::*;

  localparam int LIMIT          = 900000;
  localparam int PHASE_REQUESTS = 155;

  localparam logic [MODE_W-1:0]    MODE_STRAIGHT = 2'd0;
  localparam logic [MODE_W-1:0]    MODE_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd7;

  localparam logic signed [PE_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [PE_W-1:0] VAL_MIN = -24'sh800000;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DAT_W-1:0]       cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [MODE_W-1:0]          in_mode;
  logic signed [PE_W-1:0]     in_position_error;
  logic signed [GR_W-1:0]     in_gyro_rate;
  logic                       in_clear_history;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DRIVE_W-1:0]  out_drive_offset;
  logic [FLAGS_W-1:0]         out_sat_flags;

  int mismatch_cnt;
  int outstanding;
  int cycle_cnt      = 0;
  int burst_left     = 0;
  bit long_hold_done = 1'b0;

  cascaded_pd_heading_controller_top dut (.*);

  cpd_heading_check u_heading_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] m, input logic signed [PE_W-1:0] pe,
                              input logic signed [GR_W-1:0] gr, input logic clr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_mode           <= m;
    in_position_error <= pe;
    in_gyro_rate      <= gr;
    in_clear_history  <= clr;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                            input logic [GAIN_W-1:0] rkp, input logic [GAIN_W-1:0] rkd,
                            input logic [GLIM_W-1:0] glim);
    write_reg(REG_POS_KP, CFG_DAT_W'(kp));
    write_reg(REG_POS_KD, CFG_DAT_W'(kd));
    write_reg(REG_RATE_KP, CFG_DAT_W'(rkp));
    write_reg(REG_RATE_KD, CFG_DAT_W'(rkd));
    write_reg(REG_GYRO_LIMIT, glim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    logic [MODE_W-1:0]      m;
    logic signed [PE_W-1:0] pe;
    logic signed [GR_W-1:0] gr;
    int                     pick;
    pick = $urandom_range(0, 19);
    m = (pick < 14) ? MODE_STRAIGHT : (pick < 16) ? MODE_RIGHT :
        (pick < 18) ? MODE_LEFT : MODE_SPARE;
    if ($urandom_range(0, 4) != 0) begin
      pe = PE_W'($urandom_range(0, 40000)) - PE_W'(20000);
      gr = GR_W'($urandom_range(0, 16000)) - GR_W'(8000);
    end else begin
      pe = PE_W'($urandom);
      gr = GR_W'($urandom);
      m  = MODE_W'($urandom);
    end
    send_request(m, pe, gr, $urandom_range(0, 31) == 0);
  endtask

  // receiver stall pattern
  initial begin
    int n;
    int style;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_hold_done && cycle_cnt > 1500) begin
        long_hold_done = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
      end else begin
        style = $urandom_range(0, 9);
        n     = $urandom_range(5, 120);
        for (int i = 0; i < n; i++) begin
          @(negedge clk);
          case (style)
            0, 1, 2:    out_stall <= 1'b0;
            3, 4, 5, 6: out_stall <= ($urandom_range(0, 2) == 0);
            7, 8:       out_stall <= i[0];
            default:    out_stall <= 1'b1;
          endcase
        end
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_mode           = MODE_STRAIGHT;
    in_position_error = '0;
    in_gyro_rate      = '0;
    in_clear_history  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests at reset gains
    send_request(MODE_STRAIGHT, 0, 0, 1'b0);
    send_request(MODE_STRAIGHT, VAL_MAX, 0, 1'b0);
    send_request(MODE_STRAIGHT, VAL_MIN, 0, 1'b0);
    send_request(MODE_STRAIGHT, 0, VAL_MAX, 1'b0);
    send_request(MODE_STRAIGHT, 0, VAL_MIN, 1'b0);
    send_request(MODE_RIGHT, VAL_MAX, 0, 1'b0);
    send_request(MODE_LEFT, VAL_MIN, 0, 1'b0);
    send_request(MODE_SPARE, 1000, -500, 1'b0);
    send_request(MODE_STRAIGHT, 1000, 200, 1'b1);
    send_request(MODE_RIGHT, 0, 0, 1'b1);
    send_request(MODE_LEFT, 0, 0, 1'b0);
    send_request(MODE_STRAIGHT, 5000, 0, 1'b0);
    send_request(MODE_STRAIGHT, 5100, 50, 1'b0);
    send_request(MODE_STRAIGHT, -256, 256, 1'b0);
    send_request(MODE_STRAIGHT, -1, -1, 1'b0);
    send_request(MODE_STRAIGHT, 1, 1, 1'b0);
    send_request(MODE_RIGHT, -1, VAL_MAX, 1'b0);
    send_request(MODE_LEFT, 1, VAL_MIN, 1'b1);
    send_request(MODE_SPARE, VAL_MIN, VAL_MAX, 1'b1);
    send_request(MODE_STRAIGHT, 10317, 0, 1'b1);
    send_request(MODE_STRAIGHT, 20635, 0, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 23'h7FFFFF);
        1: load_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 23'h000000);
        2: load_gains(POS_KP_RST, POS_KD_RST, RATE_KP_RST, RATE_KD_RST, 23'h000000);
        3: load_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                      GAIN_W'($urandom), GLIM_W'($urandom));
        4: load_gains(GAIN_W'($urandom_range(0, 1023)), GAIN_W'($urandom_range(0, 1023)),
                      GAIN_W'($urandom_range(0, 1023)), GAIN_W'($urandom_range(0, 1023)),
                      GLIM_W'($urandom_range(0, 600000)));
        5: begin
          write_reg(REG_SPARE, CFG_DAT_W'($urandom));
          load_gains(POS_KP_RST, POS_KD_RST, RATE_KP_RST, RATE_KD_RST, GYRO_LIMIT_RST);
        end
        default: load_gains(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 23'h000001);
      endcase
      for (int k = 0; k < PHASE_REQUESTS; k++) random_request();
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
